// ===== src/dqpt_pkg.sv =====
// Shared types, widths and helpers for the dual quaternion point transform.
package dqpt_pkg;

	// Fraction bits of the rotation (real) part
	localparam int ROT_FRAC_BITS = 14;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_ROT_W,
		REG_ROT_X,
		REG_ROT_Y,
		REG_ROT_Z,
		REG_TR_W,
		REG_TR_X,
		REG_TR_Y,
		REG_TR_Z
	} reg_idx_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Operand and intermediate types (widths bound by worst case magnitudes)
	typedef logic signed [15:0] rot_t;    // real part component, Q1.14
	typedef logic signed [16:0] conj_t;   // negated real component, kept exact
	typedef logic signed [31:0] tr_t;     // dual part component
	typedef logic signed [31:0] coord_t;  // point coordinate
	typedef logic signed [42:0] trans_t;  // translation, full width
	typedef logic signed [35:0] uv_t;     // 2*(u x v), rounded
	typedef logic signed [47:0] pu_t;     // u * v product
	typedef logic signed [48:0] cr_t;     // u x v difference
	typedef logic signed [50:0] p4_t;     // w*uv and u*uv products
	typedef logic signed [52:0] rs_t;     // w*uv + u x uv
	typedef logic signed [39:0] rotv_t;   // rotation offset, rounded
	typedef logic signed [41:0] vr_t;     // v + rotation offset
	typedef logic signed [44:0] sum_t;    // v + rotation + translation

	// Input and result words
	typedef struct packed {
		logic signed [31:0] pt_x;
		logic signed [31:0] pt_y;
		logic signed [31:0] pt_z;
		logic               use_inverse;
	} point_t;

	typedef struct packed {
		logic signed [31:0] res_x;
		logic signed [31:0] res_y;
		logic signed [31:0] res_z;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic               ovf;
		logic signed [31:0] val;
	} sat_t;

	// Cross product index rotation over x, y, z
	localparam logic [1:0] NXT [3] = '{2'd1, 2'd2, 2'd0};
	localparam logic [1:0] PRV [3] = '{2'd2, 2'd0, 2'd1};

	localparam sum_t SAT_MAX = sum_t'(64'sh0000_0000_7FFF_FFFF);
	localparam sum_t SAT_MIN = sum_t'(-64'sh0000_0000_8000_0000);

	// Round half up, rescale by 2^-14
	function automatic logic signed [63:0] rnd14(input logic signed [63:0] x);
		return (x + (64'sd1 <<< (ROT_FRAC_BITS - 1))) >>> ROT_FRAC_BITS;
	endfunction

	// Negate a real component without losing -(-32768)
	function automatic conj_t neg_ext(input rot_t r);
		return -conj_t'(r);
	endfunction

	// Vector component of the real part in use: conjugated for inverse
	function automatic conj_t vec_sel(input rot_t r, input logic inv);
		return inv ? neg_ext(r) : conj_t'(r);
	endfunction

	// Clamp to signed 32 bits, flag the clamp
	function automatic sat_t sat32(input sum_t s);
		sat_t r;
		if (s > SAT_MAX) begin
			r.ovf = 1'b1;
			r.val = 32'sh7FFF_FFFF;
		end else if (s < SAT_MIN) begin
			r.ovf = 1'b1;
			r.val = 32'sh8000_0000;
		end else begin
			r.ovf = 1'b0;
			r.val = s[31:0];
		end
		return r;
	endfunction

endpackage

// ===== src/dqpt_pose.sv =====
// Pose unit: forward and inverse translation vectors from the held dual quaternion.
module dqpt_pose (
	input  logic             clk,
	input  dqpt_pkg::rot_t   rot [4],
	input  dqpt_pkg::tr_t    tr [4],
	output dqpt_pkg::trans_t t_fwd [3],
	output dqpt_pkg::trans_t t_inv [3]
);

	typedef logic signed [47:0] p1_t;   // d * conj(r)
	typedef logic signed [49:0] s1_t;
	typedef logic signed [35:0] tmp_t;  // rnd(d * conj(r))
	typedef logic signed [50:0] p3_t;   // conj(r) * tmp
	typedef logic signed [52:0] s3_t;
	typedef logic signed [38:0] dn_t;   // inverse dual part
	typedef logic signed [53:0] p5_t;   // d' * r
	typedef logic signed [55:0] s5_t;

	dqpt_pkg::conj_t c [4];
	p1_t              m_s1 [4][4];
	s1_t              q1 [4];
	tmp_t             tmp_s2 [4];
	dqpt_pkg::trans_t tf_s2 [3];
	p3_t              m_s3 [4][4];
	s3_t              q3 [4];
	dn_t              dn_s4 [4];
	p5_t              m_s5 [4][4];
	s5_t              q5 [4];
	dqpt_pkg::trans_t ti_s6 [3];

	// conj(r); it is both the forward conjugate and the inverse real part
	always_comb begin
		c[0] = dqpt_pkg::conj_t'(rot[0]);
		for (int k = 1; k < 4; k++) begin
			c[k] = dqpt_pkg::neg_ext(rot[k]);
		end
	end

	// Quaternion product sums: m[i][j] = a_i * b_j
	always_comb begin
		q1[0] = s1_t'(m_s1[0][0]) - s1_t'(m_s1[1][1]) - s1_t'(m_s1[2][2]) - s1_t'(m_s1[3][3]);
		q1[1] = s1_t'(m_s1[0][1]) + s1_t'(m_s1[1][0]) + s1_t'(m_s1[2][3]) - s1_t'(m_s1[3][2]);
		q1[2] = s1_t'(m_s1[0][2]) + s1_t'(m_s1[2][0]) + s1_t'(m_s1[3][1]) - s1_t'(m_s1[1][3]);
		q1[3] = s1_t'(m_s1[0][3]) + s1_t'(m_s1[3][0]) + s1_t'(m_s1[1][2]) - s1_t'(m_s1[2][1]);

		q3[0] = s3_t'(m_s3[0][0]) - s3_t'(m_s3[1][1]) - s3_t'(m_s3[2][2]) - s3_t'(m_s3[3][3]);
		q3[1] = s3_t'(m_s3[0][1]) + s3_t'(m_s3[1][0]) + s3_t'(m_s3[2][3]) - s3_t'(m_s3[3][2]);
		q3[2] = s3_t'(m_s3[0][2]) + s3_t'(m_s3[2][0]) + s3_t'(m_s3[3][1]) - s3_t'(m_s3[1][3]);
		q3[3] = s3_t'(m_s3[0][3]) + s3_t'(m_s3[3][0]) + s3_t'(m_s3[1][2]) - s3_t'(m_s3[2][1]);

		q5[0] = s5_t'(m_s5[0][0]) - s5_t'(m_s5[1][1]) - s5_t'(m_s5[2][2]) - s5_t'(m_s5[3][3]);
		q5[1] = s5_t'(m_s5[0][1]) + s5_t'(m_s5[1][0]) + s5_t'(m_s5[2][3]) - s5_t'(m_s5[3][2]);
		q5[2] = s5_t'(m_s5[0][2]) + s5_t'(m_s5[2][0]) + s5_t'(m_s5[3][1]) - s5_t'(m_s5[1][3]);
		q5[3] = s5_t'(m_s5[0][3]) + s5_t'(m_s5[3][0]) + s5_t'(m_s5[1][2]) - s5_t'(m_s5[2][1]);
	end

	// Free running chain; a register write reaches t_fwd at s2 and t_inv at s6
	always_ff @(posedge clk) begin
		// s1: d * conj(r)
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				m_s1[i][j] <= p1_t'(tr[i]) * p1_t'(c[j]);
			end
		end
		// s2: forward translation and first inverse product, rounded
		for (int i = 0; i < 4; i++) begin
			tmp_s2[i] <= tmp_t'(dqpt_pkg::rnd14(64'(q1[i])));
		end
		for (int k = 0; k < 3; k++) begin
			tf_s2[k] <= dqpt_pkg::trans_t'(dqpt_pkg::rnd14(64'(q1[k + 1]) <<< 1));
		end
		// s3: conj(r) * tmp
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				m_s3[i][j] <= p3_t'(c[i]) * p3_t'(tmp_s2[j]);
			end
		end
		// s4: inverse dual part
		for (int i = 0; i < 4; i++) begin
			dn_s4[i] <= -dn_t'(dqpt_pkg::rnd14(64'(q3[i])));
		end
		// s5: d' * conj(conj(r)) = d' * r
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				m_s5[i][j] <= p5_t'(dn_s4[i]) * p5_t'(rot[j]);
			end
		end
		// s6: inverse translation
		for (int k = 0; k < 3; k++) begin
			ti_s6[k] <= dqpt_pkg::trans_t'(dqpt_pkg::rnd14(64'(q5[k + 1]) <<< 1));
		end
	end

	assign t_fwd = tf_s2;
	assign t_inv = ti_s6;

endmodule

// ===== src/dqpt_point.sv =====
// Point pipeline: rotation by the real part, translation add and saturation.
module dqpt_point (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  dqpt_pkg::point_t  pt,
	input  dqpt_pkg::rot_t    rot [4],
	input  dqpt_pkg::trans_t  t_fwd [3],
	input  dqpt_pkg::trans_t  t_inv [3],
	output logic              out_valid,
	output dqpt_pkg::result_t res
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;

	dqpt_pkg::coord_t v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3];
	logic             inv_s1, inv_s2, inv_s3, inv_s4, inv_s5, inv_s6;

	dqpt_pkg::conj_t u1 [3], u3 [3];
	dqpt_pkg::pu_t   a_s2 [3], b_s2 [3];
	dqpt_pkg::cr_t   cr2 [3];
	dqpt_pkg::uv_t   uv_s3 [3];
	dqpt_pkg::p4_t   wuv_s4 [3], a_s4 [3], b_s4 [3];
	dqpt_pkg::rs_t   rs4 [3];
	dqpt_pkg::rotv_t rot_s5 [3];
	dqpt_pkg::vr_t   vr_s6 [3];
	dqpt_pkg::sum_t  tot6 [3];
	dqpt_pkg::sat_t  sat6 [3];
	dqpt_pkg::result_t res_s7;

	// Valid bits; the receiver never stalls, so the pipe always moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	// Rotation axis terms for the pose each word uses
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			u1[k] = dqpt_pkg::vec_sel(rot[k + 1], inv_s1);
			u3[k] = dqpt_pkg::vec_sel(rot[k + 1], inv_s3);
		end
	end

	// Cross product differences and rotation sums
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			cr2[k] = dqpt_pkg::cr_t'(a_s2[k]) - dqpt_pkg::cr_t'(b_s2[k]);
			rs4[k] = dqpt_pkg::rs_t'(wuv_s4[k]) + dqpt_pkg::rs_t'(a_s4[k])
				- dqpt_pkg::rs_t'(b_s4[k]);
		end
	end

	// Final add of the translation picked by the inverse flag, then clamp
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			tot6[k] = dqpt_pkg::sum_t'(vr_s6[k])
				+ dqpt_pkg::sum_t'(inv_s6 ? t_inv[k] : t_fwd[k]);
			sat6[k] = dqpt_pkg::sat32(tot6[k]);
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		// s1: input word
		v_s1[0] <= pt.pt_x;
		v_s1[1] <= pt.pt_y;
		v_s1[2] <= pt.pt_z;
		inv_s1  <= pt.use_inverse;

		// s2: u x v products
		for (int k = 0; k < 3; k++) begin
			a_s2[k] <= dqpt_pkg::pu_t'(u1[dqpt_pkg::NXT[k]])
				* dqpt_pkg::pu_t'(v_s1[dqpt_pkg::PRV[k]]);
			b_s2[k] <= dqpt_pkg::pu_t'(u1[dqpt_pkg::PRV[k]])
				* dqpt_pkg::pu_t'(v_s1[dqpt_pkg::NXT[k]]);
		end
		v_s2   <= v_s1;
		inv_s2 <= inv_s1;

		// s3: uv = rnd(2 * (u x v))
		for (int k = 0; k < 3; k++) begin
			uv_s3[k] <= dqpt_pkg::uv_t'(dqpt_pkg::rnd14(64'(cr2[k]) <<< 1));
		end
		v_s3   <= v_s2;
		inv_s3 <= inv_s2;

		// s4: w*uv and u x uv products
		for (int k = 0; k < 3; k++) begin
			wuv_s4[k] <= dqpt_pkg::p4_t'(rot[0]) * dqpt_pkg::p4_t'(uv_s3[k]);
			a_s4[k]   <= dqpt_pkg::p4_t'(u3[dqpt_pkg::NXT[k]])
				* dqpt_pkg::p4_t'(uv_s3[dqpt_pkg::PRV[k]]);
			b_s4[k]   <= dqpt_pkg::p4_t'(u3[dqpt_pkg::PRV[k]])
				* dqpt_pkg::p4_t'(uv_s3[dqpt_pkg::NXT[k]]);
		end
		v_s4   <= v_s3;
		inv_s4 <= inv_s3;

		// s5: rotation offset
		for (int k = 0; k < 3; k++) begin
			rot_s5[k] <= dqpt_pkg::rotv_t'(dqpt_pkg::rnd14(64'(rs4[k])));
		end
		v_s5   <= v_s4;
		inv_s5 <= inv_s4;

		// s6: v + rotation offset
		for (int k = 0; k < 3; k++) begin
			vr_s6[k] <= dqpt_pkg::vr_t'(v_s5[k]) + dqpt_pkg::vr_t'(rot_s5[k]);
		end
		inv_s6 <= inv_s5;

		// s7: result word
		res_s7.res_x    <= sat6[0].val;
		res_s7.res_y    <= sat6[1].val;
		res_s7.res_z    <= sat6[2].val;
		res_s7.overflow <= sat6[0].ovf | sat6[1].ovf | sat6[2].ovf;
	end

	assign out_valid = valid_s7;
	assign res       = res_s7;

endmodule

// ===== src/dual_quaternion_point_transform_core.sv =====
// Top level: configuration registers, pose unit and point pipeline.
// Transforms 3D points (Q16.16) by the dual quaternion held in the eight
// configuration registers: rotation by the real part (Q1.14), then the
// translation 2*vec(dual*conj(real)); use_inverse in a word applies the
// inverse pose instead. A new word is taken on every cycle that start is
// high (busy stays low). Its result is on result with done high for one
// cycle when it reaches stage s7; results come in order and there is no way
// to hold them back. The rotation runs in a 7 stage pipeline of 17x32 and
// 17x36 multipliers. Both translations come from a separate 6 stage chain
// fed only by the registers, so a word may be started in the cycle right
// after a register write. Coordinates saturate to 32 bits and overflow
// flags any clamp.
module dual_quaternion_point_transform_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  dqpt_pkg::point_t                  point,
	output logic                              done,
	output dqpt_pkg::result_t                 result,
	input  logic                              cfg_we,
	input  logic [dqpt_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [dqpt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	dqpt_pkg::rot_t   rot_q [4];
	dqpt_pkg::tr_t    tr_q [4];
	dqpt_pkg::trans_t t_fwd [3];
	dqpt_pkg::trans_t t_inv [3];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 16'sd16384;
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			rot_q[3] <= '0;
			tr_q[0]  <= '0;
			tr_q[1]  <= '0;
			tr_q[2]  <= '0;
			tr_q[3]  <= '0;
		end else if (cfg_we) begin
			case (dqpt_pkg::reg_idx_t'(cfg_idx))
				dqpt_pkg::REG_ROT_W: rot_q[0] <= cfg_data[15:0];
				dqpt_pkg::REG_ROT_X: rot_q[1] <= cfg_data[15:0];
				dqpt_pkg::REG_ROT_Y: rot_q[2] <= cfg_data[15:0];
				dqpt_pkg::REG_ROT_Z: rot_q[3] <= cfg_data[15:0];
				dqpt_pkg::REG_TR_W:  tr_q[0]  <= cfg_data;
				dqpt_pkg::REG_TR_X:  tr_q[1]  <= cfg_data;
				dqpt_pkg::REG_TR_Y:  tr_q[2]  <= cfg_data;
				dqpt_pkg::REG_TR_Z:  tr_q[3]  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Fully pipelined: a word is taken every cycle
	assign busy = 1'b0;

	dqpt_pose u_pose (
		.clk   (clk),
		.rot   (rot_q),
		.tr    (tr_q),
		.t_fwd (t_fwd),
		.t_inv (t_inv)
	);

	dqpt_point u_point (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start & ~busy),
		.pt        (point),
		.rot       (rot_q),
		.t_fwd     (t_fwd),
		.t_inv     (t_inv),
		.out_valid (done),
		.res       (result)
	);

endmodule
